### design/dtti_pkg.sv
package dtti_pkg;

	// one decimal digit
	typedef logic [3:0] digit_t;

	// parser phases
	typedef logic [2:0] phase_t;

	localparam phase_t PH_SKIP   = 3'd0;
	localparam phase_t PH_NUM    = 3'd1;
	localparam phase_t PH_EFIRST = 3'd2;
	localparam phase_t PH_EWS    = 3'd3;
	localparam phase_t PH_EDIG   = 3'd4;
	localparam phase_t PH_EDONE  = 3'd5;
	localparam phase_t PH_ERR    = 3'd6;
	localparam phase_t PH_END    = 3'd7;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_E     = 8'h65;
	localparam logic [7:0] CHAR_DOT   = 8'h2e;
	localparam logic [7:0] CHAR_PLUS  = 8'h2b;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0d;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
	endfunction

endpackage

### design/decimal_text_to_integer.sv
// Decimal text to integer.
// Input stream (s_*): one text byte per request in s_tdata, s_tlast on the final
// byte of a text. A NUL byte ends the text early; bytes after it up to s_tlast
// are ignored. Output stream (m_*): one result per text, sent after its s_tlast
// byte: the value in m_tdata, parse status and overflow flag in m_tuser.
// Throughput: one byte per cycle while a text is read. After the s_tlast byte
// the block is busy: a finishing step, then one step per power of ten applied
// by the exponent, all through the shared times-ten unit (ending early once the
// value is zero or saturates), then loading of the output register.
// The output register holds the result while m_tready is low; the next text is
// taken meanwhile, and after its final byte the input stalls until the register
// frees up.
// Reset (arst_n low) clears the parser and drops m_tvalid; the first byte after
// reset starts a new text.
module decimal_text_to_integer #(
	parameter int VALUE_BITS = 63,
	parameter int COUNT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,  // [7:0] char_code
	input  logic                                s_tlast,  // last_char
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((VALUE_BITS+7)/8)*8-1:0]     m_tdata,  // [VALUE_BITS-1:0] value
	output logic [1:0]                          m_tuser   // [0] status, [1] overflow
);
	import dtti_pkg::*;

	localparam int VB    = VALUE_BITS;
	localparam int CB    = COUNT_BITS;
	localparam int OUT_W = ((VALUE_BITS + 7) / 8) * 8;

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_FIN   = 2'd1;
	localparam logic [1:0] ST_SCALE = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0]       ctl_q;
	phase_t           phase_q;
	logic [VB-1:0]    acc_q;
	logic             ovf_q;
	logic [CB-1:0]    frac_q;
	logic [CB-1:0]    expm_q;
	logic             expneg_q;
	logic             err_q;
	logic [CB-1:0]    k_q;
	logic             status_q;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;
	logic [1:0]       m_tuser_q;

	logic [7:0]       c;
	logic             accept;
	digit_t           dig;
	digit_t           val_digit;
	logic [VB-1:0]    val_prod;
	logic             val_ovf;
	logic [CB-1:0]    exp_prod;
	logic             exp_ovf;
	logic [CB-1:0]    frac_inc;

	phase_t           n_phase;
	logic [VB-1:0]    n_acc;
	logic             n_ovf;
	logic [CB-1:0]    n_frac;
	logic [CB-1:0]    n_expm;
	logic             n_expneg;
	logic             n_err;
	logic             lead;

	logic [CB-1:0]    adj;
	logic             fin_status;
	logic             fin_scale;
	logic             out_free;

	assign c         = s_tdata;
	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (ctl_q == ST_RUN);
	assign dig       = digit_t'(c - CHAR_ZERO);
	assign val_digit = (ctl_q == ST_RUN) ? dig : '0;
	assign frac_inc  = (frac_q == '1) ? frac_q : frac_q + CB'(1);
	assign out_free  = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// shared unit: digit accumulation while reading, exponent scaling afterwards
	dtti_mul10 #(.W(VB)) u_val (
		.operand (acc_q),
		.digit   (val_digit),
		.product (val_prod),
		.ovf     (val_ovf)
	);

	dtti_mul10 #(.W(CB)) u_exp (
		.operand (expm_q),
		.digit   (dig),
		.product (exp_prod),
		.ovf     (exp_ovf)
	);

	// per-byte parser step
	always_comb begin
		n_phase  = phase_q;
		n_acc    = acc_q;
		n_ovf    = ovf_q;
		n_frac   = frac_q;
		n_expm   = expm_q;
		n_expneg = expneg_q;
		n_err    = err_q;
		lead     = 1'b0;
		unique case (phase_q) inside
			PH_SKIP, PH_NUM: begin
				if (phase_q == PH_SKIP && is_ws(c)) begin
					n_phase = phase_q;
				end else if (is_digit(c)) begin
					n_acc   = val_prod;
					n_ovf   = ovf_q | val_ovf;
					if (frac_q != '0)
						n_frac = frac_inc;
					n_phase = PH_NUM;
				end else if (c == CHAR_DOT) begin
					n_frac  = frac_inc;
					n_phase = PH_NUM;
				end else if (c == CHAR_NUL) begin
					n_phase = PH_END;
				end else if (c == CHAR_E) begin
					n_phase = PH_EFIRST;
				end else begin
					n_phase = PH_ERR;
					n_err   = 1'b1;
				end
			end
			PH_EFIRST: begin
				if (is_alpha(c) || c == CHAR_MINUS) begin
					n_phase = PH_ERR;
					n_err   = 1'b1;
				end else if (c == CHAR_PLUS) begin
					n_phase = PH_EWS;
				end else begin
					n_phase = PH_EWS;
					lead    = 1'b1;
				end
			end
			PH_EWS: lead = 1'b1;
			PH_EDIG: begin
				if (is_digit(c))
					n_expm = exp_ovf ? '1 : exp_prod;
				else
					n_phase = PH_EDONE;
			end
			default: n_phase = phase_q;
		endcase
		// exponent lead-in: whitespace, sign, first digit
		if (lead && !is_ws(c)) begin
			if (c == CHAR_PLUS) begin
				n_phase = PH_EDIG;
			end else if (c == CHAR_MINUS) begin
				n_expneg = 1'b1;
				n_phase  = PH_EDIG;
			end else if (is_digit(c)) begin
				n_expm  = CB'(dig);
				n_phase = PH_EDIG;
			end else begin
				n_phase = PH_EDONE;
			end
		end
	end

	// end-of-text checks
	always_comb begin
		adj        = (frac_q == '0) ? '0 : frac_q - CB'(1);
		fin_status = 1'b0;
		fin_scale  = 1'b0;
		if (phase_q == PH_ERR || err_q) begin
			fin_status = 1'b1;
		end else if (phase_q == PH_SKIP || phase_q == PH_NUM || phase_q == PH_END) begin
			fin_status = (frac_q != '0);
		end else if (expneg_q && expm_q != '0) begin
			fin_status = 1'b1;
		end else if (expm_q < adj) begin
			fin_status = 1'b1;
		end else begin
			fin_scale = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q      <= ST_RUN;
			phase_q    <= PH_SKIP;
			acc_q      <= '0;
			ovf_q      <= 1'b0;
			frac_q     <= '0;
			expm_q     <= '0;
			expneg_q   <= 1'b0;
			err_q      <= 1'b0;
			k_q        <= '0;
			status_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
		end else begin
			if (ctl_q == ST_OUT && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
			unique case (ctl_q)
				ST_RUN: begin
					if (accept) begin
						phase_q  <= n_phase;
						acc_q    <= n_acc;
						ovf_q    <= n_ovf;
						frac_q   <= n_frac;
						expm_q   <= n_expm;
						expneg_q <= n_expneg;
						err_q    <= n_err;
						if (s_tlast)
							ctl_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					status_q <= fin_status;
					k_q      <= expm_q - adj;
					ctl_q    <= fin_scale ? ST_SCALE : ST_OUT;
				end
				ST_SCALE: begin
					if (k_q == '0 || acc_q == '0) begin
						ctl_q <= ST_OUT;
					end else if (val_ovf) begin
						acc_q <= '1;
						ovf_q <= 1'b1;
						ctl_q <= ST_OUT;
					end else begin
						acc_q <= val_prod;
						k_q   <= k_q - CB'(1);
					end
				end
				ST_OUT: begin
					if (out_free) begin
						m_tdata_q  <= OUT_W'(acc_q);
						m_tuser_q  <= {ovf_q, status_q};
						// clear for the next text
						phase_q    <= PH_SKIP;
						acc_q      <= '0;
						ovf_q      <= 1'b0;
						frac_q     <= '0;
						expm_q     <= '0;
						expneg_q   <= 1'b0;
						err_q      <= 1'b0;
						ctl_q      <= ST_RUN;
					end
				end
				default: ctl_q <= ST_RUN;
			endcase
		end
	end

	a_last_starts_finish: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> ctl_q == ST_FIN)
		else $error("final byte did not start the finishing step");

	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(ctl_q) == ST_OUT)
		else $error("result raised outside the output step");

	a_scale_counts_down: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q == ST_SCALE |=> ctl_q != ST_SCALE || k_q == $past(k_q) - CB'(1))
		else $error("scaling step count did not advance");

	a_no_scale_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q == ST_SCALE |-> !status_q)
		else $error("failed parse went into scaling");

	a_overflow_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> &m_tdata[VB-1:0])
		else $error("overflow flagged without saturated value");

endmodule

### design/dtti_mul10.sv
// Times ten plus a digit, saturating at all ones.
module dtti_mul10 #(
	parameter int W = 63
) (
	input  logic [W-1:0]        operand,
	input  dtti_pkg::digit_t    digit,
	output logic [W-1:0]        product,
	output logic                ovf
);
	import dtti_pkg::*;

	localparam int WX = W + 4;

	logic [WX-1:0] wide;

	assign wide    = (WX'(operand) << 3) + (WX'(operand) << 1) + WX'(digit);
	assign ovf     = |wide[WX-1:W];
	assign product = ovf ? '1 : wide[W-1:0];

endmodule
